### rtl/rvex_pkg.sv
`default_nettype none

package rvex_pkg;

	localparam int unsigned XLEN     = 32;
	localparam int unsigned NUM_REGS = 32;
	localparam int unsigned REG_AW   = $clog2(NUM_REGS);
	localparam int unsigned IMM_W    = 20;
	localparam int unsigned OP_W     = 5;
	localparam int unsigned LANES_W  = 4;

	// The data store index is the low address bits, so the depth is a power of two.
	localparam int unsigned DMEM_DEPTH = 1024;
	localparam int unsigned DMEM_AW    = $clog2(DMEM_DEPTH);

	// Packed stream widths, rounded up to whole bytes.
	localparam int unsigned IN_BITS  = OP_W + 3 * REG_AW + IMM_W;
	localparam int unsigned IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int unsigned OUT_BITS = 3 * XLEN + 1 + LANES_W;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [LANES_W-1:0] LANES_NONE = 4'h0;
	localparam logic [LANES_W-1:0] LANES_BYTE = 4'h1;
	localparam logic [LANES_W-1:0] LANES_HALF = 4'h3;
	localparam logic [LANES_W-1:0] LANES_WORD = 4'hF;

	typedef enum logic [OP_W-1:0] {
		OP_SB    = 5'd0,
		OP_SH    = 5'd1,
		OP_SW    = 5'd2,
		OP_LW    = 5'd3,
		OP_LH    = 5'd4,
		OP_LHU   = 5'd5,
		OP_LB    = 5'd6,
		OP_LBU   = 5'd7,
		OP_ADDI  = 5'd8,
		OP_SLTI  = 5'd9,
		OP_SLTIU = 5'd10,
		OP_ANDI  = 5'd11,
		OP_ORI   = 5'd12,
		OP_XORI  = 5'd13,
		OP_ADD   = 5'd14,
		OP_SUB   = 5'd15,
		OP_SLT   = 5'd16,
		OP_SLTU  = 5'd17,
		OP_AND   = 5'd18,
		OP_OR    = 5'd19,
		OP_XOR   = 5'd20,
		OP_SLL   = 5'd21,
		OP_SRL   = 5'd22,
		OP_SRA   = 5'd23,
		OP_SLLI  = 5'd24,
		OP_SRLI  = 5'd25,
		OP_SRAI  = 5'd26,
		OP_LUI   = 5'd27,
		OP_AUIPC = 5'd28
	} op_t;

	typedef struct packed {
		logic [XLEN-1:0]    store_data;
		logic [XLEN-1:0]    access_addr;
		logic [XLEN-1:0]    result;
		logic               is_write;
		logic [LANES_W-1:0] byte_lanes;
		logic               wb_en;
	} exec_t;

endpackage

`default_nettype wire

### rtl/rvex_ram.sv
`default_nettype none

module rvex_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### rtl/rvex_regfile.sv
`default_nettype none

module rvex_regfile (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          we,
	input  wire logic [rvex_pkg::REG_AW-1:0]   waddr,
	input  wire logic [rvex_pkg::XLEN-1:0]     wdata,
	input  wire logic [rvex_pkg::REG_AW-1:0]   raddr_a,
	input  wire logic [rvex_pkg::REG_AW-1:0]   raddr_b,
	output logic      [rvex_pkg::XLEN-1:0]     rdata_a,
	output logic      [rvex_pkg::XLEN-1:0]     rdata_b
);

	logic [rvex_pkg::NUM_REGS-1:0] vld_q;
	logic                          vld_a_q;
	logic                          vld_b_q;
	logic [rvex_pkg::XLEN-1:0]     ram_a;
	logic [rvex_pkg::XLEN-1:0]     ram_b;

	// Two copies of the array give two read ports; both take every write.
	rvex_ram #(.WIDTH(rvex_pkg::XLEN), .DEPTH(rvex_pkg::NUM_REGS)) u_ram_a (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (1'b1),
		.raddr (raddr_a),
		.rdata (ram_a)
	);

	rvex_ram #(.WIDTH(rvex_pkg::XLEN), .DEPTH(rvex_pkg::NUM_REGS)) u_ram_b (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (1'b1),
		.raddr (raddr_b),
		.rdata (ram_b)
	);

	// An entry never written since reset reads as zero, which also covers register zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			vld_a_q <= 1'b0;
			vld_b_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			vld_a_q <= vld_q[raddr_a];
			vld_b_q <= vld_q[raddr_b];
		end
	end

	assign rdata_a = vld_a_q ? ram_a : '0;
	assign rdata_b = vld_b_q ? ram_b : '0;

endmodule

`default_nettype wire

### rtl/rvex_alu.sv
`default_nettype none

module rvex_alu (
	input  wire rvex_pkg::op_t                    op,
	input  wire logic [rvex_pkg::REG_AW-1:0]      shamt_imm,
	input  wire logic [rvex_pkg::IMM_W-1:0]       imm,
	input  wire logic [rvex_pkg::XLEN-1:0]        a,
	input  wire logic [rvex_pkg::XLEN-1:0]        b,
	input  wire logic [rvex_pkg::XLEN-1:0]        pc,
	output rvex_pkg::exec_t                       ex
);

	logic [rvex_pkg::XLEN-1:0] i12;
	logic [rvex_pkg::XLEN-1:0] upper;
	logic [rvex_pkg::XLEN-1:0] addr;
	logic [4:0]                shb;

	assign i12   = {{20{imm[11]}}, imm[11:0]};
	assign upper = {imm, 12'h000};
	assign addr  = a + i12;
	assign shb   = b[4:0];

	always_comb begin
		ex = '0;
		case (op)
			rvex_pkg::OP_SB: begin
				ex.store_data  = {24'h0, b[7:0]};
				ex.access_addr = addr;
				ex.is_write    = 1'b1;
				ex.byte_lanes  = rvex_pkg::LANES_BYTE;
			end
			rvex_pkg::OP_SH: begin
				ex.store_data  = {16'h0, b[15:0]};
				ex.access_addr = addr;
				ex.is_write    = 1'b1;
				ex.byte_lanes  = rvex_pkg::LANES_HALF;
			end
			rvex_pkg::OP_SW: begin
				ex.store_data  = b;
				ex.access_addr = addr;
				ex.is_write    = 1'b1;
				ex.byte_lanes  = rvex_pkg::LANES_WORD;
			end
			rvex_pkg::OP_LW: begin
				ex.access_addr = addr;
				ex.byte_lanes  = rvex_pkg::LANES_WORD;
				ex.wb_en       = 1'b1;
			end
			rvex_pkg::OP_LH, rvex_pkg::OP_LHU: begin
				ex.access_addr = addr;
				ex.byte_lanes  = rvex_pkg::LANES_HALF;
				ex.wb_en       = 1'b1;
			end
			rvex_pkg::OP_LB, rvex_pkg::OP_LBU: begin
				ex.access_addr = addr;
				ex.byte_lanes  = rvex_pkg::LANES_BYTE;
				ex.wb_en       = 1'b1;
			end
			rvex_pkg::OP_ADDI: begin
				ex.result = addr;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_SLTI: begin
				ex.result = {31'h0, $signed(a) < $signed(i12)};
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_SLTIU: begin
				ex.result = {31'h0, a < i12};
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_ANDI: begin
				ex.result = a & i12;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_ORI: begin
				ex.result = a | i12;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_XORI: begin
				ex.result = a ^ i12;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_ADD: begin
				ex.result = a + b;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_SUB: begin
				ex.result = a - b;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_SLT: begin
				ex.result = {31'h0, $signed(a) < $signed(b)};
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_SLTU: begin
				ex.result = {31'h0, a < b};
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_AND: begin
				ex.result = a & b;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_OR: begin
				ex.result = a | b;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_XOR: begin
				ex.result = a ^ b;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_SLL: begin
				ex.result = a << shb;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_SRL: begin
				ex.result = a >> shb;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_SRA: begin
				ex.result = 32'($signed(a) >>> shb);
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_SLLI: begin
				ex.result = a << shamt_imm;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_SRLI: begin
				ex.result = a >> shamt_imm;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_SRAI: begin
				ex.result = 32'($signed(a) >>> shamt_imm);
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_LUI: begin
				ex.result = upper;
				ex.wb_en  = 1'b1;
			end
			rvex_pkg::OP_AUIPC: begin
				ex.result = upper + pc;
				ex.wb_en  = 1'b1;
			end
			default: begin
				ex = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/rv32i_alu_load_store_exec_unit.sv
`default_nettype none

// RV32I execute unit: each input item is one decoded instruction, and each one
// gives exactly one result item describing its memory access. Items flow through
// an input stage (register operands arrive from the register file, with bypass of
// results not yet written) and a result stage that holds the output item and the
// load data, so the unit sustains one item per clock when the master side does
// not stall. A stall on the master side holds the result stage while the input
// stage still takes one more item. After reset the data store is cleared one
// word per clock; s_tready stays low until that pass ends.
module rv32i_alu_load_store_exec_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// req_type[4:0], dest_reg[9:5], src1_reg[14:10], src2_reg[19:15], immediate[39:20]
	input  wire logic [rvex_pkg::IN_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// store_data[31:0], access_addr[63:32], load_data[95:64], is_write[96],
	// byte_lanes[100:97], zero fill above
	output logic      [rvex_pkg::OUT_W-1:0]    m_tdata
);

	localparam int unsigned AW = rvex_pkg::DMEM_AW;
	localparam int unsigned RW = rvex_pkg::REG_AW;
	localparam int unsigned XW = rvex_pkg::XLEN;

	rvex_pkg::op_t             in_op;
	logic [RW-1:0]             in_rd;
	logic [RW-1:0]             in_rs1;
	logic [RW-1:0]             in_rs2;
	logic [rvex_pkg::IMM_W-1:0] in_imm;
	logic                      s_fire;
	logic                      adv2;
	logic                      adv1;

	logic                      valid_s1;
	rvex_pkg::op_t             op_s1;
	logic [RW-1:0]             rd_s1;
	logic [RW-1:0]             rs1_s1;
	logic [RW-1:0]             rs2_s1;
	logic [rvex_pkg::IMM_W-1:0] imm_s1;

	logic                      valid_s2;
	rvex_pkg::op_t             op_s2;
	logic [RW-1:0]             rd_s2;
	logic                      wbe_s2;
	logic [XW-1:0]             res_s2;
	logic [XW-1:0]             sdata_s2;
	logic [XW-1:0]             addr_s2;
	logic                      wr_s2;
	logic [rvex_pkg::LANES_W-1:0] lanes_s2;

	logic [XW-1:0]             pc_q;
	logic                      clr_busy_q;
	logic [AW-1:0]             clr_cnt_q;
	logic                      wr_pend_q;
	logic                      lw_vld_q;
	logic [RW-1:0]             lw_addr_q;
	logic [XW-1:0]             lw_data_q;

	logic [RW-1:0]             raddr_a;
	logic [RW-1:0]             raddr_b;
	logic [XW-1:0]             rf_a;
	logic [XW-1:0]             rf_b;
	logic [XW-1:0]             opa;
	logic [XW-1:0]             opb;
	logic                      rf_we;

	rvex_pkg::exec_t           ex;

	logic                      dm_we;
	logic [AW-1:0]             dm_waddr;
	logic [XW-1:0]             dm_wdata;
	logic                      dm_re;
	logic [XW-1:0]             dm_rdata;
	logic [XW-1:0]             load_data;
	logic [XW-1:0]             ld_wb;
	logic                      is_load_s2;
	logic [XW-1:0]             wb_data_s2;

	assign in_op  = rvex_pkg::op_t'(s_tdata[4:0]);
	assign in_rd  = s_tdata[9:5];
	assign in_rs1 = s_tdata[14:10];
	assign in_rs2 = s_tdata[19:15];
	assign in_imm = s_tdata[39:20];

	assign adv2     = !valid_s2 || m_tready;
	assign adv1     = valid_s1 && adv2;
	assign s_tready = !clr_busy_q && (!valid_s1 || adv2);
	assign s_fire   = s_tvalid && s_tready;

	// Register file is read every clock: the new item's sources when one is taken,
	// otherwise the held item's sources again so that a stalled item sees later writes.
	assign raddr_a = s_fire ? in_rs1 : rs1_s1;
	assign raddr_b = s_fire ? in_rs2 : rs2_s1;
	assign rf_we   = wr_pend_q && wbe_s2;

	rvex_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (rf_we),
		.waddr   (rd_s2),
		.wdata   (wb_data_s2),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rf_a),
		.rdata_b (rf_b)
	);

	// Bypass: the result stage holds the newest older item; the write done at the
	// last edge was missed by the read at that same edge.
	always_comb begin
		if (valid_s2 && wbe_s2 && (rd_s2 == rs1_s1)) begin
			opa = wb_data_s2;
		end else if (lw_vld_q && (lw_addr_q == rs1_s1)) begin
			opa = lw_data_q;
		end else begin
			opa = rf_a;
		end
		if (valid_s2 && wbe_s2 && (rd_s2 == rs2_s1)) begin
			opb = wb_data_s2;
		end else if (lw_vld_q && (lw_addr_q == rs2_s1)) begin
			opb = lw_data_q;
		end else begin
			opb = rf_b;
		end
	end

	rvex_alu u_alu (
		.op        (op_s1),
		.shamt_imm (rs2_s1),
		.imm       (imm_s1),
		.a         (opa),
		.b         (opb),
		.pc        (pc_q),
		.ex        (ex)
	);

	// Stores write as the item leaves the input stage, so a following load reads
	// the new word; loads read at the same moment and the word lands with the result.
	assign dm_we    = clr_busy_q || (adv1 && ex.is_write);
	assign dm_waddr = clr_busy_q ? clr_cnt_q : ex.access_addr[AW-1:0];
	assign dm_wdata = clr_busy_q ? '0 : ex.store_data;
	assign dm_re    = adv1;

	rvex_ram #(.WIDTH(XW), .DEPTH(rvex_pkg::DMEM_DEPTH)) u_dstore (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.re    (dm_re),
		.raddr (ex.access_addr[AW-1:0]),
		.rdata (dm_rdata)
	);

	always_comb begin
		load_data  = '0;
		ld_wb      = '0;
		is_load_s2 = 1'b1;
		case (op_s2)
			rvex_pkg::OP_LW: begin
				load_data = dm_rdata;
				ld_wb     = dm_rdata;
			end
			rvex_pkg::OP_LH: begin
				load_data = {16'h0, dm_rdata[15:0]};
				ld_wb     = {{16{dm_rdata[15]}}, dm_rdata[15:0]};
			end
			rvex_pkg::OP_LHU: begin
				load_data = {16'h0, dm_rdata[15:0]};
				ld_wb     = {16'h0, dm_rdata[15:0]};
			end
			rvex_pkg::OP_LB: begin
				load_data = {24'h0, dm_rdata[7:0]};
				ld_wb     = {{24{dm_rdata[7]}}, dm_rdata[7:0]};
			end
			rvex_pkg::OP_LBU: begin
				load_data = {24'h0, dm_rdata[7:0]};
				ld_wb     = {24'h0, dm_rdata[7:0]};
			end
			default: begin
				is_load_s2 = 1'b0;
			end
		endcase
	end

	assign wb_data_s2 = is_load_s2 ? ld_wb : res_s2;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			pc_q       <= '0;
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			wr_pend_q  <= 1'b0;
			lw_vld_q   <= 1'b0;
		end else begin
			if (s_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv1) begin
				valid_s1 <= 1'b0;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			if (adv1) begin
				pc_q <= pc_q + 32'd4;
			end
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
				if (clr_cnt_q == AW'(rvex_pkg::DMEM_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			wr_pend_q <= adv1;
			lw_vld_q  <= rf_we;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			op_s1  <= in_op;
			rd_s1  <= in_rd;
			rs1_s1 <= in_rs1;
			rs2_s1 <= in_rs2;
			imm_s1 <= in_imm;
		end
		if (adv1) begin
			op_s2    <= op_s1;
			rd_s2    <= rd_s1;
			wbe_s2   <= ex.wb_en && (rd_s1 != '0);
			res_s2   <= ex.result;
			sdata_s2 <= ex.store_data;
			addr_s2  <= ex.access_addr;
			wr_s2    <= ex.is_write;
			lanes_s2 <= ex.byte_lanes;
		end
		if (rf_we) begin
			lw_addr_q <= rd_s2;
			lw_data_q <= wb_data_s2;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(rvex_pkg::OUT_W - rvex_pkg::OUT_BITS)'(0), lanes_s2, wr_s2,
		load_data, addr_s2, sdata_s2};

`ifndef ASSERT_OFF
	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_fire)
		else $error("item accepted during data store clearing");

	a_no_write_to_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |-> (rd_s2 != '0))
		else $error("register zero written");

	a_pc_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 |=> (pc_q == $past(pc_q) + 32'd4))
		else $error("program counter did not advance by four");

	a_store_has_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && wr_s2) |-> (lanes_s2 != rvex_pkg::LANES_NONE && !is_load_s2))
		else $error("store result without byte lanes");

	a_load_data_only_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !is_load_s2) |-> (load_data == '0))
		else $error("load data on a non-load result");
`endif

endmodule

`default_nettype wire

### tb/sv/rv32i_exec_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels of the execute unit. It keeps its own copy of the
// register file, program counter and data store, works out the access that each
// accepted instruction must produce, and compares every output item against the
// oldest prediction.
module rv32i_exec_checker
	import rvex_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	input  wire logic             s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,
	input  wire logic             m_tvalid,
	input  wire logic             m_tready,
	input  wire logic [OUT_W-1:0] m_tdata,
	output int                    fail_count,
	output int                    pending
);

	localparam int MAX_PRINTS = 40;

	typedef struct packed {
		logic [XLEN-1:0]    store_data;
		logic [XLEN-1:0]    access_addr;
		logic [XLEN-1:0]    load_data;
		logic               is_write;
		logic [LANES_W-1:0] byte_lanes;
	} mem_access_t;

	logic [XLEN-1:0] gpr [NUM_REGS];
	logic [XLEN-1:0] pc_q;
	logic [XLEN-1:0] dmem_words [DMEM_DEPTH];
	mem_access_t     exp_access [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	task automatic report_mismatch(input string field, input logic [XLEN-1:0] got,
			input logic [XLEN-1:0] want);
		if (fail_count < MAX_PRINTS)
			$display("%0t: %s got %h want %h", $time, field, got, want);
		fail_count++;
	endtask

	// Executes one instruction against the local state and returns its access.
	function automatic mem_access_t execute_instr(input logic [IN_W-1:0] item);
		logic [OP_W-1:0]    code;
		logic [REG_AW-1:0]  rd, rs1, rs2;
		logic [IMM_W-1:0]   imm;
		logic [XLEN-1:0]    a, b, i12, addr, res, word;
		logic [DMEM_AW-1:0] slot;
		logic               wb;
		mem_access_t        r;
		code = item[4:0];
		rd   = item[9:5];
		rs1  = item[14:10];
		rs2  = item[19:15];
		imm  = item[39:20];
		a    = gpr[rs1];
		b    = gpr[rs2];
		i12  = {{20{imm[11]}}, imm[11:0]};
		addr = a + i12;
		slot = addr[DMEM_AW-1:0];
		word = dmem_words[slot];
		r    = '0;
		res  = '0;
		wb   = 1'b1;
		case (code)
			OP_SB, OP_SH, OP_SW: begin
				r.byte_lanes  = (code == OP_SB) ? LANES_BYTE :
					(code == OP_SH) ? LANES_HALF : LANES_WORD;
				r.store_data  = (code == OP_SB) ? {24'h0, b[7:0]} :
					(code == OP_SH) ? {16'h0, b[15:0]} : b;
				r.access_addr = addr;
				r.is_write    = 1'b1;
				dmem_words[slot] = r.store_data;
				wb = 1'b0;
			end
			OP_LW: begin
				r.access_addr = addr;
				r.load_data   = word;
				r.byte_lanes  = LANES_WORD;
				res = word;
			end
			OP_LH, OP_LHU: begin
				r.access_addr = addr;
				r.load_data   = {16'h0, word[15:0]};
				r.byte_lanes  = LANES_HALF;
				res = (code == OP_LH) ? {{16{word[15]}}, word[15:0]} : r.load_data;
			end
			OP_LB, OP_LBU: begin
				r.access_addr = addr;
				r.load_data   = {24'h0, word[7:0]};
				r.byte_lanes  = LANES_BYTE;
				res = (code == OP_LB) ? {{24{word[7]}}, word[7:0]} : r.load_data;
			end
			OP_ADDI:  res = a + i12;
			OP_SLTI:  res = {31'h0, $signed(a) < $signed(i12)};
			OP_SLTIU: res = {31'h0, a < i12};
			OP_ANDI:  res = a & i12;
			OP_ORI:   res = a | i12;
			OP_XORI:  res = a ^ i12;
			OP_ADD:   res = a + b;
			OP_SUB:   res = a - b;
			OP_SLT:   res = {31'h0, $signed(a) < $signed(b)};
			OP_SLTU:  res = {31'h0, a < b};
			OP_AND:   res = a & b;
			OP_OR:    res = a | b;
			OP_XOR:   res = a ^ b;
			OP_SLL:   res = a << b[4:0];
			OP_SRL:   res = a >> b[4:0];
			OP_SRA:   res = $signed(a) >>> b[4:0];
			OP_SLLI:  res = a << rs2;
			OP_SRLI:  res = a >> rs2;
			OP_SRAI:  res = $signed(a) >>> rs2;
			OP_LUI:   res = {imm, 12'h0};
			OP_AUIPC: res = {imm, 12'h0} + pc_q;
			default:  wb = 1'b0;
		endcase
		if (wb && rd != '0)
			gpr[rd] = res;
		pc_q = pc_q + 32'd4;
		return r;
	endfunction

	task automatic check_access(input logic [OUT_W-1:0] word);
		mem_access_t want;
		if (exp_access.size() == 0) begin
			report_mismatch("item with no prediction, store_data", word[XLEN-1:0], '0);
			return;
		end
		want = exp_access.pop_front();
		if (word[XLEN-1:0] !== want.store_data)
			report_mismatch("store_data", word[XLEN-1:0], want.store_data);
		if (word[2*XLEN-1:XLEN] !== want.access_addr)
			report_mismatch("access_addr", word[2*XLEN-1:XLEN], want.access_addr);
		if (word[3*XLEN-1:2*XLEN] !== want.load_data)
			report_mismatch("load_data", word[3*XLEN-1:2*XLEN], want.load_data);
		if (word[3*XLEN] !== want.is_write)
			report_mismatch("is_write", {31'h0, word[3*XLEN]}, {31'h0, want.is_write});
		if (word[3*XLEN+LANES_W:3*XLEN+1] !== want.byte_lanes)
			report_mismatch("byte_lanes", {28'h0, word[3*XLEN+LANES_W:3*XLEN+1]},
				{28'h0, want.byte_lanes});
		if (word[OUT_W-1:OUT_BITS] !== '0)
			report_mismatch("fill bits", XLEN'(word[OUT_W-1:OUT_BITS]), '0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				gpr[i] = '0;
			for (int i = 0; i < DMEM_DEPTH; i++)
				dmem_words[i] = '0;
			pc_q = '0;
			exp_access.delete();
			pending <= 0;
		end else begin
			// An item accepted on this edge cannot leave on the same edge, so the
			// output side is checked first.
			if (m_tvalid && m_tready)
				check_access(m_tdata);
			if (s_tvalid && s_tready)
				exp_access.push_back(execute_instr(s_tdata));
			pending <= exp_access.size();
		end
	end

endmodule

### tb/sv/tb_rv32i_alu_load_store_exec_unit.sv
`timescale 1ns / 100ps

module tb_rv32i_alu_load_store_exec_unit;
	import rvex_pkg::*;

	// Covers the store clearing pass after reset plus the longest stalls.
	localparam int IDLE_LIMIT = 5000;
	localparam int PHASE_ITEMS = 150;
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 5'd29;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tready = 1'b0;
	logic             s_tready;
	logic             m_tvalid;
	logic [OUT_W-1:0] m_tdata;
	int               fail_count;
	int               pending;
	bit               free_run = 1'b0;
	int               ready_hold = 0;
	int               idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	rv32i_alu_load_store_exec_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rv32i_exec_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Receiver side: ready and stall stretches of random length, or always ready in free run.
	always @(negedge clk) begin
		if (free_run) begin
			m_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 9) < 6) begin
			m_tready   <= 1'b1;
			ready_hold <= $urandom_range(0, 7);
		end else begin
			m_tready   <= 1'b0;
			ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
				$urandom_range(0, 2);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("rv32i_alu_load_store_exec_unit: mismatch");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (free_run || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [REG_AW-1:0] rd,
			input logic [REG_AW-1:0] rs1, input logic [REG_AW-1:0] rs2,
			input logic [IMM_W-1:0] imm);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {imm, rs2, rs1, rd, op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Memory items mostly use x1..x3 as base with small offsets, so loads land
	// on entries that stores have written.
	task automatic run_random_phase(input int count);
		int r;
		logic [OP_W-1:0]   op;
		logic [REG_AW-1:0] rd, rs1, rs2;
		logic [IMM_W-1:0]  imm;
		send_item(OP_ADDI, 5'd1, 5'd0, 5'd0, IMM_W'($urandom));
		for (int i = 0; i < count; i++) begin
			r   = $urandom_range(0, 99);
			rd  = ($urandom_range(0, 9) == 0) ? REG_AW'($urandom) :
				REG_AW'($urandom_range(4, 31));
			rs1 = REG_AW'($urandom);
			rs2 = REG_AW'($urandom);
			imm = IMM_W'($urandom);
			if (r < 50) begin
				op = (r < 22) ? OP_W'($urandom_range(OP_SB, OP_SW)) :
					OP_W'($urandom_range(OP_LW, OP_LBU));
				if (r % 5 != 0) begin
					rs1 = REG_AW'($urandom_range(1, 3));
					imm[11:0] = 12'($urandom_range(0, 31)) - 12'd16;
				end
			end else if (r < 96) begin
				op = OP_W'($urandom_range(OP_ADDI, OP_AUIPC));
			end else begin
				op = OP_W'($urandom_range(OP_UNUSED_LO, 31));
			end
			send_item(op, rd, rs1, rs2, imm);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_item(OP_ADDI, 5'd1, 5'd0, 5'd0, 20'h007FF);
		send_item(OP_ADDI, 5'd2, 5'd0, 5'd0, 20'h00800);
		send_item(OP_LUI, 5'd3, 5'd0, 5'd0, 20'hFFFFF);
		// Writes to register zero must be dropped.
		send_item(OP_LUI, 5'd0, 5'd0, 5'd0, 20'h12345);
		send_item(OP_ADDI, 5'd5, 5'd0, 5'd0, 20'h00005);
		send_item(OP_AUIPC, 5'd4, 5'd0, 5'd0, 20'h00001);
		// Address 2048 wraps onto store entry zero.
		send_item(OP_SW, 5'd0, 5'd1, 5'd3, 20'h00001);
		send_item(OP_LW, 5'd6, 5'd0, 5'd0, 20'h00000);
		// Address 0xFFFFFFFF lands on the top entry.
		send_item(OP_SH, 5'd0, 5'd2, 5'd2, 20'h007FF);
		send_item(OP_LH, 5'd7, 5'd2, 5'd0, 20'h007FF);
		send_item(OP_LHU, 5'd8, 5'd2, 5'd0, 20'h007FF);
		send_item(OP_SB, 5'd0, 5'd0, 5'd1, 20'h00004);
		send_item(OP_LB, 5'd9, 5'd0, 5'd0, 20'h00004);
		send_item(OP_LBU, 5'd10, 5'd0, 5'd0, 20'h00004);
		send_item(OP_SLTI, 5'd12, 5'd2, 5'd0, 20'h00000);
		send_item(OP_SLTIU, 5'd13, 5'd1, 5'd0, 20'hFFFFF);
		send_item(OP_ANDI, 5'd14, 5'd3, 5'd0, 20'hFFFFF);
		send_item(OP_ORI, 5'd15, 5'd1, 5'd0, 20'h00800);
		send_item(OP_XORI, 5'd16, 5'd2, 5'd0, 20'hFFFFF);
		send_item(OP_ADD, 5'd17, 5'd3, 5'd2, 20'h00000);
		// Operand order matters for the subtract.
		send_item(OP_SUB, 5'd18, 5'd1, 5'd5, 20'h00000);
		send_item(OP_SLT, 5'd19, 5'd2, 5'd1, 20'h00000);
		send_item(OP_SLTU, 5'd20, 5'd2, 5'd1, 20'h00000);
		send_item(OP_AND, 5'd21, 5'd3, 5'd2, 20'h00000);
		send_item(OP_OR, 5'd22, 5'd3, 5'd1, 20'h00000);
		send_item(OP_XOR, 5'd23, 5'd3, 5'd2, 20'h00000);
		send_item(OP_SLL, 5'd24, 5'd1, 5'd5, 20'h00000);
		send_item(OP_SRL, 5'd25, 5'd2, 5'd5, 20'h00000);
		send_item(OP_SRA, 5'd26, 5'd2, 5'd5, 20'h00000);
		send_item(OP_SLLI, 5'd27, 5'd1, 5'd31, 20'h00000);
		send_item(OP_SRLI, 5'd28, 5'd2, 5'd31, 20'h00000);
		send_item(OP_SRAI, 5'd29, 5'd2, 5'd31, 20'h00000);
		// Unused codes change nothing but still move the program counter.
		for (int c = OP_UNUSED_LO; c < (1 << OP_W); c++)
			send_item(OP_W'(c), 5'h1F, 5'h1F, 5'h1F, 20'hFFFFF);

		for (int phase = 0; phase < 5; phase++) begin
			free_run = (phase == 2);
			run_random_phase(PHASE_ITEMS);
		end
		free_run = 1'b0;
		s_tvalid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("rv32i_alu_load_store_exec_unit: match");
		else
			$display("rv32i_alu_load_store_exec_unit: mismatch");
		$finish;
	end

endmodule
